FILE: design/plb_pkg.sv
// Shared types and constants for the price level book.
package plb_pkg;

   localparam int unsigned LEVELS_DEFAULT = 64;
   localparam int unsigned PRICE_W = 32;
   localparam int unsigned SHARES_W = 32;
   localparam int unsigned REQ_DATA_W = 64;
   localparam int unsigned REQ_USER_W = 2;
   localparam int unsigned RSP_DATA_W = 136;

   localparam logic CMD_ADD = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   localparam logic SIDE_BID = 1'b0;
   localparam logic SIDE_ASK = 1'b1;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_UNKNOWN = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic [1:0] ST_SAT = 2'd3;

   localparam logic [SHARES_W-1:0] SHARES_MAX = '1;

   typedef struct packed {
      logic load;
      logic compare;
      logic update;
   } dp_cmd_type;

endpackage

FILE: design/price_level_book.sv
// Top level of the price level book: bid and ask level tables with best price report.
//
// Input beats carry one add or remove of shares at a price on one side.
// Each accepted beat returns exactly one result beat with the best bid, the
// best ask and a status code (ok, unknown level, table full, saturated).
// A beat is taken in the idle state, compared against every level of its side
// in the next cycle, applied to the sorted cell row in the cycle after, and
// the result is shown in the respond state that follows, until it is accepted;
// a new beat is taken the cycle after the result is accepted.
// While the receiver stalls, the result beat holds and no new beat is taken.
// Reset empties both sides and returns the controller to idle; the level
// cells themselves are not cleared, since only cells below a side's count
// are ever used.
module price_level_book #(
   parameter int unsigned LEVELS_PER_SIDE = plb_pkg::LEVELS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // price, shares
   input  logic [plb_pkg::REQ_DATA_W-1:0]     req_tdata,
   // command, side
   input  logic [plb_pkg::REQ_USER_W-1:0]     req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // bid valid, bid price, bid shares, ask valid, ask price,
   // ask shares, status, zero padding
   output logic [plb_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import plb_pkg::*;

   dp_cmd_type          dp_cmd;
   logic                bid_valid, ask_valid;
   logic [PRICE_W-1:0]  top_bid_price, top_ask_price;
   logic [SHARES_W-1:0] top_bid_shares, top_ask_shares;
   logic [1:0]          status;

   plb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dp_cmd     (dp_cmd)
   );

   plb_datapath #(
      .LEVELS_PER_SIDE (LEVELS_PER_SIDE)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .dp_cmd          (dp_cmd),
      .in_command      (req_tuser[0]),
      .in_side         (req_tuser[1]),
      .in_price        (req_tdata[31:0]),
      .in_shares       (req_tdata[63:32]),
      .bid_valid       (bid_valid),
      .top_bid_price   (top_bid_price),
      .top_bid_shares  (top_bid_shares),
      .ask_valid       (ask_valid),
      .top_ask_price   (top_ask_price),
      .top_ask_shares  (top_ask_shares),
      .status          (status)
   );

   assign rsp_tdata = {4'b0000, status, top_ask_shares, top_ask_price, ask_valid,
                       top_bid_shares, top_bid_price, bid_valid};

endmodule

FILE: design/plb_ctrl.sv
// Controller state machine that sequences one beat through compare and update.
module plb_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output plb_pkg::dp_cmd_type dp_cmd
);
   import plb_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_COMPARE,
      S_UPDATE,
      S_RESPOND
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_COMPARE;
         end
         S_COMPARE: state_in = S_UPDATE;
         S_UPDATE: state_in = S_RESPOND;
         S_RESPOND: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESPOND);
   assign dp_cmd.load = req_tready & req_tvalid;
   assign dp_cmd.compare = (state_ff == S_COMPARE);
   assign dp_cmd.update = (state_ff == S_UPDATE);

endmodule

FILE: design/plb_datapath.sv
// Datapath with one sorted row of level cells per side, best level kept in cell zero.
module plb_datapath #(
   parameter int unsigned LEVELS_PER_SIDE = plb_pkg::LEVELS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  plb_pkg::dp_cmd_type                 dp_cmd,
   input  logic                                in_command,
   input  logic                                in_side,
   input  logic [plb_pkg::PRICE_W-1:0]         in_price,
   input  logic [plb_pkg::SHARES_W-1:0]        in_shares,
   output logic                                bid_valid,
   output logic [plb_pkg::PRICE_W-1:0]         top_bid_price,
   output logic [plb_pkg::SHARES_W-1:0]        top_bid_shares,
   output logic                                ask_valid,
   output logic [plb_pkg::PRICE_W-1:0]         top_ask_price,
   output logic [plb_pkg::SHARES_W-1:0]        top_ask_shares,
   output logic [1:0]                          status
);
   import plb_pkg::*;

   localparam int unsigned N = LEVELS_PER_SIDE;
   localparam int unsigned CW = $clog2(N + 1);

   logic                command_ff, side_ff;
   logic [PRICE_W-1:0]  price_ff;
   logic [SHARES_W-1:0] shares_ff;

   logic [PRICE_W-1:0]  cell_price_ff [2][N];
   logic [SHARES_W-1:0] cell_shares_ff [2][N];
   logic [CW-1:0]       count_ff [2];

   logic [N-1:0]        match_ff, match_in;
   logic [N-1:0]        better_ff, better_in;
   logic [SHARES_W-1:0] hit_shares_ff, hit_shares_in;
   logic                hit_ff;
   logic [1:0]          status_ff, status_in;

   logic [PRICE_W-1:0]  next_price [N];
   logic [SHARES_W-1:0] next_shares [N];
   logic [CW-1:0]       next_count;
   logic [SHARES_W:0]   sum;

   always_comb begin
      hit_shares_in = '0;
      for (int i = 0; i < N; i++) begin
         logic v;
         logic [PRICE_W-1:0] pr;
         v = CW'(i) < count_ff[side_ff];
         pr = cell_price_ff[side_ff][i];
         match_in[i] = v && (pr == price_ff);
         better_in[i] = v && ((side_ff == SIDE_ASK) ? (pr < price_ff) : (pr > price_ff));
         hit_shares_in = hit_shares_in | (match_in[i] ? cell_shares_ff[side_ff][i] : '0);
      end
   end

   always_comb begin
      for (int i = 0; i < N; i++) begin
         next_price[i] = cell_price_ff[side_ff][i];
         next_shares[i] = cell_shares_ff[side_ff][i];
      end
      next_count = count_ff[side_ff];
      status_in = ST_OK;
      sum = {1'b0, hit_shares_ff} + {1'b0, shares_ff};
      if (command_ff == CMD_ADD) begin
         if (hit_ff) begin
            for (int i = 0; i < N; i++) begin
               if (match_ff[i]) next_shares[i] = sum[SHARES_W] ? SHARES_MAX : sum[SHARES_W-1:0];
            end
            if (sum[SHARES_W]) status_in = ST_SAT;
         end else if (count_ff[side_ff] == CW'(N)) begin
            status_in = ST_FULL;
         end else begin
            if (!better_ff[0]) begin
               next_price[0] = price_ff;
               next_shares[0] = shares_ff;
            end
            for (int i = 1; i < N; i++) begin
               if (!better_ff[i]) begin
                  if (better_ff[i-1]) begin
                     next_price[i] = price_ff;
                     next_shares[i] = shares_ff;
                  end else begin
                     next_price[i] = cell_price_ff[side_ff][i-1];
                     next_shares[i] = cell_shares_ff[side_ff][i-1];
                  end
               end
            end
            next_count = count_ff[side_ff] + CW'(1);
         end
      end else begin
         if (!hit_ff) begin
            status_in = ST_UNKNOWN;
         end else if (hit_shares_ff <= shares_ff) begin
            for (int i = 0; i < N - 1; i++) begin
               if (!better_ff[i]) begin
                  next_price[i] = cell_price_ff[side_ff][i+1];
                  next_shares[i] = cell_shares_ff[side_ff][i+1];
               end
            end
            next_count = count_ff[side_ff] - CW'(1);
         end else begin
            for (int i = 0; i < N; i++) begin
               if (match_ff[i]) next_shares[i] = hit_shares_ff - shares_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         command_ff <= in_command;
         side_ff <= in_side;
         price_ff <= in_price;
         shares_ff <= in_shares;
      end
      if (dp_cmd.compare) begin
         match_ff <= match_in;
         better_ff <= better_in;
         hit_shares_ff <= hit_shares_in;
         hit_ff <= |match_in;
      end
      if (dp_cmd.update) begin
         status_ff <= status_in;
         for (int i = 0; i < N; i++) begin
            cell_price_ff[side_ff][i] <= next_price[i];
            cell_shares_ff[side_ff][i] <= next_shares[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff[0] <= '0;
         count_ff[1] <= '0;
      end else if (dp_cmd.update) begin
         count_ff[side_ff] <= next_count;
      end
   end

   assign bid_valid = (count_ff[0] != '0);
   assign top_bid_price = bid_valid ? cell_price_ff[0][0] : '0;
   assign top_bid_shares = bid_valid ? cell_shares_ff[0][0] : '0;
   assign ask_valid = (count_ff[1] != '0);
   assign top_ask_price = ask_valid ? cell_price_ff[1][0] : '0;
   assign top_ask_shares = ask_valid ? cell_shares_ff[1][0] : '0;
   assign status = status_ff;

endmodule

FILE: verif/price_level_book_tb.sv
// Self-checking testbench for the price level book: directed, table-full and random traffic.
module price_level_book_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import plb_pkg::*;

   localparam int LEVELS = LEVELS_DEFAULT;
   localparam int POOL = 80;

   typedef struct packed {
      logic        bid_valid;
      logic [31:0] bid_price;
      logic [31:0] bid_shares;
      logic        ask_valid;
      logic [31:0] ask_price;
      logic [31:0] ask_shares;
      logic [1:0]  status;
   } quote_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   logic [31:0] book_price [2][LEVELS];
   logic [31:0] book_shares [2][LEVELS];
   int book_count [2];
   quote_type pending_quotes[$];
   int errors = 0;
   int beats_sent = 0;
   int beats_checked = 0;
   int status_seen [4];
   logic [31:0] price_pool [2][POOL];
   bit hold_off = 1'b0;
   int burst_left = 0;

   price_level_book u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("FAIL");
      $finish;
   end

   function automatic int find_level(int s, logic [31:0] price);
      for (int i = 0; i < book_count[s]; i++) begin
         if (book_price[s][i] == price) return i;
      end
      return -1;
   endfunction

   function automatic quote_type apply_order(logic cmd, logic s, logic [31:0] price,
                                             logic [31:0] shares);
      quote_type q;
      int hit;
      int pos;
      logic [32:0] sum;
      hit = find_level(s, price);
      q.status = ST_OK;
      if (cmd == CMD_ADD) begin
         if (hit >= 0) begin
            sum = {1'b0, book_shares[s][hit]} + {1'b0, shares};
            if (sum[32]) begin
               book_shares[s][hit] = SHARES_MAX;
               q.status = ST_SAT;
            end else begin
               book_shares[s][hit] = sum[31:0];
            end
         end else if (book_count[s] >= LEVELS) begin
            q.status = ST_FULL;
         end else begin
            pos = book_count[s];
            while (pos > 0 && book_price[s][pos-1] > price) begin
               book_price[s][pos] = book_price[s][pos-1];
               book_shares[s][pos] = book_shares[s][pos-1];
               pos--;
            end
            book_price[s][pos] = price;
            book_shares[s][pos] = shares;
            book_count[s]++;
         end
      end else if (hit < 0) begin
         q.status = ST_UNKNOWN;
      end else if (book_shares[s][hit] <= shares) begin
         for (int i = hit + 1; i < book_count[s]; i++) begin
            book_price[s][i-1] = book_price[s][i];
            book_shares[s][i-1] = book_shares[s][i];
         end
         book_count[s]--;
      end else begin
         book_shares[s][hit] -= shares;
      end
      q.bid_valid = book_count[SIDE_BID] > 0;
      q.bid_price = q.bid_valid ? book_price[SIDE_BID][book_count[SIDE_BID]-1] : '0;
      q.bid_shares = q.bid_valid ? book_shares[SIDE_BID][book_count[SIDE_BID]-1] : '0;
      q.ask_valid = book_count[SIDE_ASK] > 0;
      q.ask_price = q.ask_valid ? book_price[SIDE_ASK][0] : '0;
      q.ask_shares = q.ask_valid ? book_shares[SIDE_ASK][0] : '0;
      return q;
   endfunction

   task automatic send_order(logic cmd, logic s, logic [31:0] price, logic [31:0] shares);
      int gap;
      quote_type q;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata = {shares, price};
      req_tuser = {s, cmd};
      do @(posedge clock); while (!req_tready);
      q = apply_order(cmd, s, price, shares);
      pending_quotes.insert(pending_quotes.size(), q);
      beats_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_quotes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Receiver: switches among random stall patterns, with long hold-offs on request.
   initial begin
      int mode;
      int hold;
      forever begin
         mode = $urandom_range(0, 2);
         for (int c = 0; c < 64; c++) begin
            @(negedge clock);
            if (hold_off) begin
               rsp_tready = 1'b0;
               for (hold = 0; hold < 300; hold++) @(negedge clock);
               hold_off = 1'b0;
            end
            case (mode)
               0: rsp_tready = 1'b1;
               1: rsp_tready = $urandom_range(0, 1);
               default: rsp_tready = ($urandom_range(0, 5) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      quote_type e;
      quote_type a;
      if (!reset && rsp_tvalid && rsp_tready) begin
         a.bid_valid = rsp_tdata[0];
         a.bid_price = rsp_tdata[32:1];
         a.bid_shares = rsp_tdata[64:33];
         a.ask_valid = rsp_tdata[65];
         a.ask_price = rsp_tdata[97:66];
         a.ask_shares = rsp_tdata[129:98];
         a.status = rsp_tdata[131:130];
         if (pending_quotes.size() == 0) begin
            $display("%0t: unexpected result beat %h", $time, rsp_tdata);
            errors++;
         end else begin
            e = pending_quotes.pop_front();
            beats_checked++;
            status_seen[e.status]++;
            if (a !== e) begin
               $display("%0t: mismatch expected bv=%0b bp=%h bs=%h av=%0b ap=%h as=%h st=%0d",
                        $time, e.bid_valid, e.bid_price, e.bid_shares, e.ask_valid,
                        e.ask_price, e.ask_shares, e.status);
               $display("%0t:          actual   bv=%0b bp=%h bs=%h av=%0b ap=%h as=%h st=%0d",
                        $time, a.bid_valid, a.bid_price, a.bid_shares, a.ask_valid,
                        a.ask_price, a.ask_shares, a.status);
               errors++;
            end
         end
      end
   end

   task automatic test_directed();
      send_order(CMD_REMOVE, SIDE_BID, 32'd5, 32'd1);
      send_order(CMD_ADD, SIDE_BID, 32'd100, 32'd10);
      send_order(CMD_ADD, SIDE_BID, 32'd0, 32'd0);
      send_order(CMD_ADD, SIDE_BID, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_order(CMD_ADD, SIDE_BID, 32'hFFFF_FFFF, 32'd1);
      send_order(CMD_ADD, SIDE_BID, 32'd100, 32'hFFFF_FFF5);
      send_order(CMD_ADD, SIDE_ASK, 32'd200, 32'd5);
      send_order(CMD_ADD, SIDE_ASK, 32'hFFFF_FFFF, 32'd3);
      send_order(CMD_ADD, SIDE_ASK, 32'd0, 32'd7);
      send_order(CMD_ADD, SIDE_ASK, 32'hAAAA_5555, 32'h5555_AAAA);
      send_order(CMD_REMOVE, SIDE_BID, 32'd555, 32'd1);
      send_order(CMD_REMOVE, SIDE_ASK, 32'd200, 32'd2);
      send_order(CMD_REMOVE, SIDE_ASK, 32'd200, 32'd3);
      send_order(CMD_REMOVE, SIDE_ASK, 32'd0, 32'hFFFF_FFFF);
      send_order(CMD_REMOVE, SIDE_BID, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
      send_order(CMD_REMOVE, SIDE_BID, 32'hFFFF_FFFF, 32'd1);
      send_order(CMD_REMOVE, SIDE_BID, 32'd0, 32'd0);
      send_order(CMD_REMOVE, SIDE_BID, 32'd100, 32'd0);
      send_order(CMD_REMOVE, SIDE_ASK, 32'hFFFF_FFFF, 32'd10);
      send_order(CMD_REMOVE, SIDE_ASK, 32'hAAAA_5555, 32'hFFFF_FFFF);
      send_order(CMD_REMOVE, SIDE_BID, 32'd100, 32'hFFFF_FFFF);
      wait_drained();
   endtask

   // Fills each side to capacity, adds new and existing levels when full, then empties it.
   task automatic test_table_full();
      logic [31:0] p;
      for (int s = 0; s < 2; s++) begin
         while (book_count[s] < LEVELS) begin
            send_order(CMD_ADD, s[0], $urandom, $urandom_range(1, 1000));
         end
         if (s == 1) hold_off = 1'b1;
         repeat (3) send_order(CMD_ADD, s[0], $urandom, 32'd9);
         send_order(CMD_ADD, s[0], book_price[s][LEVELS/2], 32'd9);
         while (book_count[s] > 0) begin
            p = book_price[s][$urandom_range(0, book_count[s] - 1)];
            send_order(CMD_REMOVE, s[0], p, 32'hFFFF_FFFF);
         end
      end
      wait_drained();
   endtask

   task automatic test_random();
      logic s;
      logic [31:0] p;
      logic [31:0] n;
      int hit;
      for (int s2 = 0; s2 < 2; s2++) begin
         for (int i = 0; i < POOL; i++) price_pool[s2][i] = $urandom;
      end
      for (int k = 0; k < 1100; k++) begin
         s = $urandom_range(0, 1);
         p = ($urandom_range(0, 15) == 0) ? $urandom : price_pool[s][$urandom_range(0, POOL-1)];
         case ($urandom_range(0, 3))
            0: n = $urandom;
            1: n = $urandom_range(0, 3);
            default: n = $urandom_range(1, 5000);
         endcase
         if ($urandom_range(0, 9) < 6) begin
            send_order(CMD_ADD, s, p, n);
         end else begin
            hit = find_level(s, p);
            if (hit >= 0 && $urandom_range(0, 1)) n = book_shares[s][hit] - $urandom_range(0, 1);
            send_order(CMD_REMOVE, s, p, n);
         end
         if (k == 500) hold_off = 1'b1;
         if (k == 700) wait_drained();
      end
      wait_drained();
   endtask

   initial begin
      book_count[0] = 0;
      book_count[1] = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_table_full();
      test_random();
      $display("Sent %0d order beats, checked %0d quote beats.", beats_sent, beats_checked);
      $display("Status counts: ok %0d, unknown %0d, full %0d, saturated %0d.",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      if (errors == 0 && pending_quotes.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
